// ===== rtl/exponential_histogram_window_counter_top_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef EXPONENTIAL_HISTOGRAM_WINDOW_COUNTER_TOP_DEFINES_SVH
`define EXPONENTIAL_HISTOGRAM_WINDOW_COUNTER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EHWC_ASSERT_ALW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define EHWC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EHWC_ASSERT_ALW(lbl, expr, msg)
`define EHWC_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ehwc_pkg.sv =====
package ehwc_pkg;

  localparam int EHWC_MAX_BUCKETS = 64;
  localparam int EXP_W            = 5;
  localparam int TIME_W           = 31;
  localparam int WIN_W            = 31;
  localparam int MK_W             = 8;
  localparam int CFG_W            = 31;
  localparam int EST_W            = 32;
  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd1024;
  localparam logic [MK_W-1:0]  MERGE_K_RESET = 8'd2;

  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_MERGE_K = 1'b1;

  typedef enum logic [1:0] {
    KIND_INC   = 2'd0,
    KIND_DEC   = 2'd1,
    KIND_Q_POS = 2'd2,
    KIND_Q_NET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CMD_NOP    = 3'd0,
    CMD_SHIFT  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_TAIL   = 3'd3,
    CMD_LEFT   = 3'd4,
    CMD_MERGE  = 3'd5,
    CMD_HEAD   = 3'd6,
    CMD_RIGHT  = 3'd7
  } cmd_t;

  typedef struct packed {
    logic              head_valid;
    logic [TIME_W-1:0] head_time;
    logic              full;
    logic              cur_valid;
    logic [EXP_W-1:0]  cur_exp;
    logic              cur_eq_prev;
  } hist_status_t;

endpackage

// ===== rtl/ehwc_cell.sv =====
module ehwc_cell
  import ehwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [TIME_W-1:0] now,
  input  logic              is_first,
  input  logic              above_cur,
  input  logic              l_valid,
  input  logic [EXP_W-1:0]  l_exp,
  input  logic              l_cur,
  input  logic              r_valid,
  input  logic [EXP_W-1:0]  r_exp,
  input  logic [TIME_W-1:0] r_time,
  input  logic              r_cur,
  output logic              valid,
  output logic [EXP_W-1:0]  exp_o,
  output logic [TIME_W-1:0] time_o,
  output logic              cur,
  output logic              eq_left
);

  logic              valid_r, valid_nxt;
  logic              cur_r, cur_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;

  always_comb begin
    valid_nxt = valid_r;
    cur_nxt   = cur_r;
    exp_nxt   = exp_r;
    time_nxt  = time_r;
    unique case (cmd)
      CMD_NOP: begin
      end
      CMD_SHIFT: begin
        valid_nxt = r_valid;
        exp_nxt   = r_exp;
        time_nxt  = r_time;
      end
      CMD_APPEND: begin
        if (!valid_r && (is_first || l_valid)) begin
          valid_nxt = 1'b1;
          exp_nxt   = '0;
          time_nxt  = now;
        end
      end
      CMD_TAIL: cur_nxt = valid_r && !r_valid;
      CMD_LEFT: cur_nxt = r_cur;
      CMD_MERGE: begin
        if (cur_r) begin
          exp_nxt  = exp_r + EXP_W'(1);
          time_nxt = r_time;
        end else if (above_cur) begin
          valid_nxt = r_valid;
          exp_nxt   = r_exp;
          time_nxt  = r_time;
        end
      end
      CMD_HEAD:  cur_nxt = is_first;
      CMD_RIGHT: cur_nxt = !is_first && l_cur;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cur_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r  <= exp_nxt;
    time_r <= time_nxt;
  end

  assign valid   = valid_r;
  assign exp_o   = exp_r;
  assign time_o  = time_r;
  assign cur     = cur_r;
  assign eq_left = valid_r && !is_first && l_valid && (exp_r == l_exp);

endmodule

// ===== rtl/ehwc_hist.sv =====
`include "exponential_histogram_window_counter_top_defines.svh"

module ehwc_hist
  import ehwc_pkg::*;
#(
  parameter int MAX_BUCKETS = EHWC_MAX_BUCKETS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic [TIME_W-1:0] now,
  output hist_status_t      status
);

  logic [MAX_BUCKETS-1:0] valid_v;
  logic [MAX_BUCKETS-1:0] cur_v;
  logic [MAX_BUCKETS-1:0] eq_v;
  logic [MAX_BUCKETS-1:0] above_v;
  logic [EXP_W-1:0]       exp_a  [MAX_BUCKETS];
  logic [TIME_W-1:0]      time_a [MAX_BUCKETS];

  assign above_v = ~(cur_v - MAX_BUCKETS'(1)) & ~cur_v;

  for (genvar i = 0; i < MAX_BUCKETS; i++) begin : g_cell
    logic              l_valid, l_cur, r_valid, r_cur;
    logic [EXP_W-1:0]  l_exp, r_exp;
    logic [TIME_W-1:0] r_time;

    if (i == 0) begin : g_first
      assign l_valid = 1'b0;
      assign l_cur   = 1'b0;
      assign l_exp   = '0;
    end else begin : g_mid
      assign l_valid = valid_v[i-1];
      assign l_cur   = cur_v[i-1];
      assign l_exp   = exp_a[i-1];
    end

    if (i == MAX_BUCKETS - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_cur   = 1'b0;
      assign r_exp   = '0;
      assign r_time  = '0;
    end else begin : g_inner
      assign r_valid = valid_v[i+1];
      assign r_cur   = cur_v[i+1];
      assign r_exp   = exp_a[i+1];
      assign r_time  = time_a[i+1];
    end

    ehwc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .now       (now),
      .is_first  (i == 0),
      .above_cur (above_v[i]),
      .l_valid   (l_valid),
      .l_exp     (l_exp),
      .l_cur     (l_cur),
      .r_valid   (r_valid),
      .r_exp     (r_exp),
      .r_time    (r_time),
      .r_cur     (r_cur),
      .valid     (valid_v[i]),
      .exp_o     (exp_a[i]),
      .time_o    (time_a[i]),
      .cur       (cur_v[i]),
      .eq_left   (eq_v[i])
    );
  end

  always_comb begin
    status             = '0;
    status.head_valid  = valid_v[0];
    status.head_time   = time_a[0];
    status.full        = valid_v[MAX_BUCKETS-1];
    status.cur_valid   = |(cur_v & valid_v);
    status.cur_eq_prev = |(cur_v & eq_v);
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      status.cur_exp = status.cur_exp | (exp_a[i] & {EXP_W{cur_v[i]}});
    end
  end

  `EHWC_ASSERT_ALW(a_cur_onehot, $onehot0(cur_v), "cursor is not one-hot")
  `EHWC_ASSERT_ALW(a_valid_prefix, ((valid_v + MAX_BUCKETS'(1)) & valid_v) == '0, "hole in list")
  `EHWC_ASSERT_IMP(a_append_lands, (cmd == CMD_APPEND) && !valid_v[MAX_BUCKETS-1], valid_v[0], "append lost")

endmodule

// ===== rtl/exponential_histogram_window_counter_top.sv =====
// Sliding-window event counter built from two exponential histograms.
// Input channel: in_kind and in_time_stamp, transferred when in_valid is high
// and in_stall is low. Kinds 0 and 1 add an increment or decrement arrival and
// give no result; kinds 2 and 3 give one result on the output channel.
// Output channel: out_estimate and out_overflow_seen, transferred when
// out_valid is high and out_stall is low. The result sits in an output
// register and holds while out_stall is high; the next item is not taken
// until the current one has finished, and a stalled result holds up only a
// later query, which waits to load the output register. An arrival first
// expires old buckets at the head and then, unless the list is full, appends
// a bucket and runs the merge walk of cursor steps and merges. A query
// expires old buckets and then sums the buckets left from the head before it
// loads the output register; a net query walks both lists, and the load
// waits while an earlier result is still held by out_stall. The walks run
// one cell a cycle along the row of MAX_BUCKETS cells.
// Configuration writes on cfg_write_en take effect at once and are to be made
// only while the block is idle; the block itself does not enforce this.
// Synchronous reset empties both lists, clears the overflow flag and
// returns window_length to 1024 and merge_k to 2.
`include "exponential_histogram_window_counter_top_defines.svh"

module exponential_histogram_window_counter_top
  import ehwc_pkg::*;
#(
  parameter int MAX_BUCKETS = EHWC_MAX_BUCKETS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_kind,
  input  logic [TIME_W-1:0]       in_time_stamp,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [EST_W-1:0] out_estimate,
  output logic                    out_overflow_seen,
  input  logic                    cfg_write_en,
  input  logic                    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int RUN_W = $clog2(MAX_BUCKETS + 1);
  localparam int LIM_W = 9;
  localparam int CMP_W = (RUN_W > LIM_W) ? RUN_W : LIM_W;
  localparam int ACC_W = 34 + $clog2(MAX_BUCKETS);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(32'sh8000_0000);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPIRE,
    ST_CASC_INIT,
    ST_CASC_SCAN,
    ST_Q_HEAD,
    ST_Q_SUM,
    ST_Q_OUT
  } state_t;

  state_t                    state_r;
  kind_t                     kind_r;
  logic [TIME_W-1:0]         now_r;
  logic                      sel_r;
  logic                      first_r;
  logic [RUN_W-1:0]          run_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      ovf_r;
  logic [WIN_W-1:0]          window_r;
  logic [MK_W-1:0]           merge_k_r;
  logic                      out_valid_r;
  logic signed [EST_W-1:0]   out_est_r;
  logic                      out_ovf_r;

  hist_status_t              inc_st, dec_st, st;
  cmd_t                      cmd, inc_cmd, dec_cmd;
  logic signed [EST_W:0]     age;
  logic                      expired;
  logic                      is_arrival;
  logic [LIM_W-1:0]          limit;
  logic                      can_merge;
  logic [EXP_W-1:0]          sh;
  logic [ACC_W-1:0]          contrib;
  logic signed [EST_W-1:0]   sat;

  assign st         = sel_r ? dec_st : inc_st;
  assign age        = $signed({2'b00, now_r}) - $signed({2'b00, st.head_time});
  assign expired    = st.head_valid && (age >= $signed({2'b00, window_r}));
  assign is_arrival = (kind_r == KIND_INC) || (kind_r == KIND_DEC);
  assign limit      = LIM_W'(2) + LIM_W'(merge_k_r >> 1);
  assign can_merge  = (CMP_W'(run_r) >= CMP_W'(limit)) && (st.cur_exp < EXP_MAX);
  assign sh         = (first_r && st.cur_exp != '0) ? st.cur_exp - EXP_W'(1) : st.cur_exp;
  assign contrib    = ACC_W'(1) << sh;

  always_comb begin
    if (acc_r > SAT_HI) begin
      sat = EST_W'(SAT_HI);
    end else if (acc_r < SAT_LO) begin
      sat = EST_W'(SAT_LO);
    end else begin
      sat = EST_W'(acc_r);
    end
  end

  always_comb begin
    cmd = CMD_NOP;
    unique case (state_r)
      ST_IDLE: cmd = CMD_NOP;
      ST_EXPIRE: begin
        if (expired) begin
          cmd = CMD_SHIFT;
        end else if (is_arrival && !st.full) begin
          cmd = CMD_APPEND;
        end
      end
      ST_CASC_INIT: cmd = CMD_TAIL;
      ST_CASC_SCAN: begin
        if (st.cur_eq_prev) begin
          cmd = CMD_LEFT;
        end else if (can_merge) begin
          cmd = CMD_MERGE;
        end
      end
      ST_Q_HEAD: cmd = CMD_HEAD;
      ST_Q_SUM:  cmd = st.cur_valid ? CMD_RIGHT : CMD_NOP;
      ST_Q_OUT:  cmd = CMD_NOP;
      default:   cmd = CMD_NOP;
    endcase
  end

  assign inc_cmd = sel_r ? CMD_NOP : cmd;
  assign dec_cmd = sel_r ? cmd : CMD_NOP;

  ehwc_hist #(.MAX_BUCKETS(MAX_BUCKETS)) u_inc (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (inc_cmd),
    .now    (now_r),
    .status (inc_st)
  );

  ehwc_hist #(.MAX_BUCKETS(MAX_BUCKETS)) u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (dec_cmd),
    .now    (now_r),
    .status (dec_st)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RESET;
      merge_k_r   <= MERGE_K_RESET;
      sel_r       <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        unique case (cfg_index)
          REG_WINDOW:  window_r  <= cfg_data[WIN_W-1:0];
          REG_MERGE_K: merge_k_r <= cfg_data[MK_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid_r && !out_stall && (state_r != ST_Q_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind_t'(in_kind);
            now_r   <= in_time_stamp;
            sel_r   <= (kind_t'(in_kind) == KIND_DEC);
            acc_r   <= '0;
            state_r <= ST_EXPIRE;
          end
        end
        ST_EXPIRE: begin
          if (!expired) begin
            if (is_arrival) begin
              if (st.full) begin
                ovf_r   <= 1'b1;
                state_r <= ST_IDLE;
              end else begin
                state_r <= ST_CASC_INIT;
              end
            end else begin
              state_r <= ST_Q_HEAD;
            end
          end
        end
        ST_CASC_INIT: begin
          run_r   <= RUN_W'(1);
          state_r <= ST_CASC_SCAN;
        end
        ST_CASC_SCAN: begin
          if (st.cur_eq_prev) begin
            run_r <= run_r + RUN_W'(1);
          end else if (can_merge) begin
            run_r <= RUN_W'(1);
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_Q_HEAD: begin
          first_r <= 1'b1;
          state_r <= ST_Q_SUM;
        end
        ST_Q_SUM: begin
          if (st.cur_valid) begin
            acc_r   <= sel_r ? acc_r - $signed(contrib) : acc_r + $signed(contrib);
            first_r <= 1'b0;
          end else if ((kind_r == KIND_Q_NET) && !sel_r) begin
            sel_r   <= 1'b1;
            state_r <= ST_EXPIRE;
          end else begin
            state_r <= ST_Q_OUT;
          end
        end
        ST_Q_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_est_r   <= sat;
            out_ovf_r   <= ovf_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_estimate      = out_est_r;
  assign out_overflow_seen = out_ovf_r;

  `EHWC_ASSERT_IMP(a_ovf_sticky, ovf_r, ovf_r, "overflow flag cleared")
  `EHWC_ASSERT_IMP(a_arrival_no_result, (state_r == ST_CASC_SCAN) && !out_valid_r, !out_valid_r, "arrival produced a result")
  `EHWC_ASSERT_IMP(a_out_load, (state_r == ST_Q_OUT) && !out_valid_r, out_valid_r && (state_r == ST_IDLE), "result not loaded")

endmodule
